[sv/arwc_pkg.sv]
package arwc_pkg;

   // Sequence number width and bitmap row geometry
   localparam int unsigned SEQ_BITS = 64;
   localparam int unsigned ROW_BITS = 64;
   localparam int unsigned LO_BITS  = 6;

   // Row write operations of the bitmap unit
   typedef enum logic [2:0] {
      WR_ZERO  = 3'b001,
      WR_CLEAR = 3'b010,
      WR_SET   = 3'b100
   } wr_op_type;

   // Command from the sequencer to the bitmap unit; lo..hi-1 selects the bit range
   typedef struct packed {
      logic               rd_en;
      logic               wr_en;
      wr_op_type          wr_op;
      logic [LO_BITS-1:0] lo;
      logic [LO_BITS:0]   hi;
   } bm_cmd_type;

endpackage

[sv/anti_replay_window_check_unit.sv]
// Channel   | Ports                              | Handshake
// ----------+------------------------------------+-------------------------------------
// request   | start, busy, req_sequence_number   | word taken when start=1 and busy=0
// response  | rsp_valid, rsp_accept              | one-cycle strobe, always taken
//
// Bitmap is a ring of 64-bit rows indexed by sequence number modulo the ring size; an advance
// clears only the bits the jump passes over. Reset sweeps all 2**ROW_AW rows with busy high.
// Zero and words older than the window are answered from the compares alone; a tested word
// is read, then written, on the one bitmap port; an advance reads and clears each row it
// touches, or clears all 2**ROW_AW rows when the jump reaches the ring size. busy drops as
// the strobe rises, and the result receiver cannot stall the unit.
module anti_replay_window_check_unit #(
   parameter int unsigned WINDOW_BITS = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] req_sequence_number,
   output logic        busy,
   output logic        rsp_valid,
   output logic        rsp_accept
);
   import arwc_pkg::*;

   localparam int unsigned ROW_AW = (WINDOW_BITS <= 2 * ROW_BITS) ? 1 :
                                    $clog2((WINDOW_BITS + ROW_BITS - 1) / ROW_BITS);
   localparam int unsigned RB = ROW_AW + LO_BITS;

   typedef enum logic [9:0] {
      ST_IDLE    = 10'b0000000001,
      ST_CMP     = 10'b0000000010,
      ST_NEG     = 10'b0000000100,
      ST_CLR_ALL = 10'b0000001000,
      ST_CLR_RD  = 10'b0000010000,
      ST_CLR_WR  = 10'b0000100000,
      ST_SET_RD  = 10'b0001000000,
      ST_SET_WR  = 10'b0010000000,
      ST_TEST_RD = 10'b0100000000,
      ST_TEST_WR = 10'b1000000000
   } state_type;

   state_type           state_ff, state_in;
   logic [SEQ_BITS-1:0] seq_ff, seq_in;
   logic [SEQ_BITS-1:0] high_ff, high_in;
   logic [RB-1:0]       cur_ff, cur_in;
   logic [RB-1:0]       rem_ff, rem_in;
   logic [ROW_AW-1:0]   row_cnt_ff, row_cnt_in;
   logic                init_ff, init_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_accept_ff, rsp_accept_in;

   logic [SEQ_BITS-1:0] sub_a;
   logic [SEQ_BITS-1:0] sub_b;
   logic [SEQ_BITS:0]   diff_full;
   logic [SEQ_BITS-1:0] diff;
   logic                borrow;
   logic                far_jump;
   logic                in_window;
   logic [LO_BITS:0]    room;
   logic                rem_fits;
   logic [LO_BITS:0]    chunk;
   logic [LO_BITS:0]    chunk_end;
   logic [LO_BITS:0]    seq_end;
   bm_cmd_type          cmd;
   logic [ROW_AW-1:0]   row;
   logic                hit;

   // Shared subtractor: seq - high on compare, high - seq on the older path
   always_comb begin
      if (state_ff == ST_NEG) begin
         sub_a = high_ff;
         sub_b = seq_ff;
      end else begin
         sub_a = seq_ff;
         sub_b = high_ff;
      end
      diff_full = {1'b0, sub_a} - {1'b0, sub_b};
      diff      = diff_full[SEQ_BITS-1:0];
      borrow    = diff_full[SEQ_BITS];
      far_jump  = |diff[SEQ_BITS-1:RB];
      in_window = diff < SEQ_BITS'(WINDOW_BITS);
   end

   // Size the clear step: up to the end of the current row
   always_comb begin
      room      = (LO_BITS + 1)'(ROW_BITS) - {1'b0, cur_ff[LO_BITS-1:0]};
      rem_fits  = rem_ff <= RB'(room);
      chunk     = rem_fits ? rem_ff[LO_BITS:0] : room;
      chunk_end = {1'b0, cur_ff[LO_BITS-1:0]} + chunk;
      seq_end   = {1'b0, seq_ff[LO_BITS-1:0]} + (LO_BITS + 1)'(1);
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      seq_in        = seq_ff;
      high_in       = high_ff;
      cur_in        = cur_ff;
      rem_in        = rem_ff;
      row_cnt_in    = row_cnt_ff;
      init_in       = init_ff;
      rsp_valid_in  = 1'b0;
      rsp_accept_in = rsp_accept_ff;
      cmd.rd_en     = 1'b0;
      cmd.wr_en     = 1'b0;
      cmd.wr_op     = WR_SET;
      cmd.lo        = seq_ff[LO_BITS-1:0];
      cmd.hi        = seq_end;
      row           = seq_ff[RB-1:LO_BITS];
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               seq_in   = req_sequence_number;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (seq_ff == '0) begin
               rsp_valid_in  = 1'b1;
               rsp_accept_in = 1'b0;
               state_in      = ST_IDLE;
            end else if (!borrow && diff != '0) begin
               if (far_jump) begin
                  row_cnt_in = '0;
                  state_in   = ST_CLR_ALL;
               end else begin
                  cur_in   = high_ff[RB-1:0] + RB'(1);
                  rem_in   = diff[RB-1:0];
                  state_in = ST_CLR_RD;
               end
            end else begin
               state_in = ST_NEG;
            end
         end
         ST_NEG: begin
            if (in_window) begin
               state_in = ST_TEST_RD;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_accept_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         ST_CLR_ALL: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_op  = WR_ZERO;
            row        = row_cnt_ff;
            row_cnt_in = row_cnt_ff + ROW_AW'(1);
            if (&row_cnt_ff) begin
               if (init_ff) begin
                  init_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_SET_RD;
               end
            end
         end
         ST_CLR_RD: begin
            cmd.rd_en = 1'b1;
            row       = cur_ff[RB-1:LO_BITS];
            state_in  = ST_CLR_WR;
         end
         ST_CLR_WR: begin
            cmd.wr_en = 1'b1;
            cmd.wr_op = WR_CLEAR;
            cmd.lo    = cur_ff[LO_BITS-1:0];
            cmd.hi    = chunk_end;
            row       = cur_ff[RB-1:LO_BITS];
            cur_in    = cur_ff + RB'(chunk);
            rem_in    = rem_ff - RB'(chunk);
            state_in  = rem_fits ? ST_SET_RD : ST_CLR_RD;
         end
         ST_SET_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_SET_WR;
         end
         ST_SET_WR: begin
            cmd.wr_en     = 1'b1;
            high_in       = seq_ff;
            rsp_valid_in  = 1'b1;
            rsp_accept_in = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_TEST_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_TEST_WR;
         end
         ST_TEST_WR: begin
            cmd.wr_en     = !hit;
            rsp_valid_in  = 1'b1;
            rsp_accept_in = !hit;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Bitmap row store and mask unit
   arwc_bitmap #(
      .ROW_AW(ROW_AW)
   ) u_bitmap (
      .clock(clock),
      .cmd  (cmd),
      .row  (row),
      .hit  (hit)
   );

   // Control state; reset starts the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR_ALL;
         high_ff      <= '0;
         row_cnt_ff   <= '0;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         high_ff      <= high_in;
         row_cnt_ff   <= row_cnt_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the word and the clear walk
   always_ff @(posedge clock) begin
      seq_ff        <= seq_in;
      cur_ff        <= cur_in;
      rem_ff        <= rem_in;
      rsp_accept_ff <= rsp_accept_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_accept = rsp_accept_ff;

endmodule

[sv/arwc_bitmap.sv]
module arwc_bitmap #(
   parameter int unsigned ROW_AW = 6
) (
   input  logic                 clock,
   input  arwc_pkg::bm_cmd_type cmd,
   input  logic [ROW_AW-1:0]    row,
   output logic                 hit
);
   import arwc_pkg::*;

   localparam int unsigned ROWS = 2 ** ROW_AW;

   logic [ROW_BITS-1:0] bits_ff [ROWS];
   logic [ROW_BITS-1:0] rd_data_ff;
   logic [ROW_BITS-1:0] lo_mask;
   logic [ROW_BITS-1:0] hi_mask;
   logic [ROW_BITS-1:0] mask;
   logic [ROW_BITS-1:0] wr_data;

   // Build the range mask: bits lo up to, not including, hi
   always_comb begin
      lo_mask = {ROW_BITS{1'b1}} << cmd.lo;
      hi_mask = cmd.hi[LO_BITS] ? '0 : ({ROW_BITS{1'b1}} << cmd.hi[LO_BITS-1:0]);
      mask    = lo_mask & ~hi_mask;
   end

   // Modify the row read in the previous cycle
   always_comb begin
      unique case (cmd.wr_op)
         WR_CLEAR: wr_data = rd_data_ff & ~mask;
         WR_SET:   wr_data = rd_data_ff | mask;
         default:  wr_data = '0;
      endcase
   end

   // Test the selected bit of the row read last cycle
   assign hit = |(rd_data_ff & mask);

   // Row storage, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         bits_ff[row] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= bits_ff[row];
      end
   end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

// Replay filter checker: keeps its own copy of the highest accepted number and of
// the bitmap, predicts accept or reject per word and compares results in order
class replay_scoreboard #(int unsigned WINDOW_BITS = 4096);

   logic [63:0]            highest;
   logic [WINDOW_BITS-1:0] seen_map;
   bit                     verdicts[$];
   int                     errors;

   function new();
      highest  = '0;
      seen_map = '0;
      errors   = 0;
   endfunction

   // Print one line per mismatch and count it
   task report_mismatch(input string what);
      errors++;
      $display("[%0t] MISMATCH: %s", $realtime, what);
   endtask

   // Update the window for one word taken by the unit and queue the expected verdict
   function void note_word(input logic [63:0] seq);
      logic [63:0] gap;
      bit          verdict;

      verdict = 1'b0;
      if (seq != '0) begin
         if (seq > highest) begin
            // advance the window, clearing it fully on a jump of a whole window
            gap = seq - highest;
            if (gap >= WINDOW_BITS)
               seen_map = '0;
            else
               seen_map = seen_map << gap;
            seen_map[0] = 1'b1;
            highest     = seq;
            verdict     = 1'b1;
         end else begin
            // test and mark a number at or below the highest
            gap = highest - seq;
            if (gap < WINDOW_BITS && !seen_map[int'(gap)]) begin
               seen_map[int'(gap)] = 1'b1;
               verdict             = 1'b1;
            end
         end
      end
      verdicts.push_back(verdict);
   endfunction

   // Compare one result strobe with the oldest expected verdict
   task check_result(input logic accept);
      bit want;

      if (verdicts.size() == 0) begin
         report_mismatch($sformatf("unexpected result, accept=%0b", accept));
      end else begin
         want = verdicts.pop_front();
         if (accept !== want)
            report_mismatch($sformatf("accept=%0b, expected %0b", accept, want));
      end
   endtask

   function int pending();
      return verdicts.size();
   endfunction

endclass

module tb_top;

   localparam int unsigned WINDOW_BITS = 4096;
   localparam int          IDLE_LIMIT  = 4000;
   localparam int          DRAIN_WAIT  = 200;
   localparam int          RANDOM_WORDS = 700;

   typedef logic [arwc_pkg::SEQ_BITS-1:0] seq_type;

   logic    clock;
   logic    reset;
   logic    start;
   seq_type req_sequence_number;
   logic    busy;
   logic    rsp_valid;
   logic    rsp_accept;

   replay_scoreboard #(WINDOW_BITS) sb;
   seq_type recent[$];
   int      burst_left;
   int      idle_cycles;

   anti_replay_window_check_unit #(
      .WINDOW_BITS(WINDOW_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_sequence_number(req_sequence_number),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .rsp_accept(rsp_accept)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Check every result strobe
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_result(rsp_accept);
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Pick an idle gap: mostly none or short, a few long, with idle-free bursts
   function int pick_gap();
      int roll;

      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         burst_left = $urandom_range(10, 30);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 80);
   endfunction

   // Drive one word after the given gap and hold it until taken
   task send_word(input seq_type seq, input int gap);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start               <= 1'b1;
      req_sequence_number <= seq;
      do @(posedge clock); while (busy);
      sb.note_word(seq);
      recent.push_back(seq);
      if (recent.size() > 32)
         void'(recent.pop_front());
   endtask

   // Build a random word relative to the current highest number
   function seq_type pick_sequence();
      seq_type top;
      int      roll;

      top  = sb.highest;
      roll = $urandom_range(0, 99);
      if (roll < 30) return top - $urandom_range(0, WINDOW_BITS - 1);
      if (roll < 40) return top - $urandom_range(WINDOW_BITS - 8, WINDOW_BITS + 7);
      if (roll < 52) return recent[$urandom_range(0, recent.size() - 1)];
      if (roll < 72) return top + $urandom_range(1, 64);
      if (roll < 84) return top + $urandom_range(65, WINDOW_BITS - 1);
      if (roll < 88) return top + $urandom_range(WINDOW_BITS, 70000);
      if (roll < 89) return top + {$urandom_range(0, 255), $urandom()};
      if (roll < 94) return '0;
      // far too old: below the random base region
      return {2'b00, 30'($urandom()), $urandom()};
   endfunction

   initial begin
      seq_type seq;
      seq_type opening[$];
      seq_type closing[$];

      sb                  = new();
      burst_left          = 0;
      idle_cycles         = 0;
      reset               = 1'b1;
      start               = 1'b0;
      req_sequence_number = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // zero, equal, in-window, word crossing, full clear, window edge
      opening = '{64'd0, 64'd1, 64'd1, 64'd5, 64'd3, 64'd3, 64'd2, 64'd100, 64'd36,
                  64'd36, 64'd4196, 64'd100, 64'd101, 64'd8291, 64'd4196, 64'd4197,
                  64'd8355, 64'd8354, 64'd8291, 64'd0};
      foreach (opening[i])
         send_word(opening[i], pick_gap());

      // move to a random base with bit 62 set, then random traffic
      send_word({2'b01, 30'($urandom()), $urandom()}, pick_gap());
      repeat (RANDOM_WORDS) begin
         seq = pick_sequence();
         send_word(seq, pick_gap());
      end

      // top of the number range
      closing = '{64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE,
                  64'hFFFF_FFFF_FFFF_F001, 64'hFFFF_FFFF_FFFF_F000,
                  64'h7FFF_FFFF_FFFF_FFFF, 64'd0};
      foreach (closing[i])
         send_word(closing[i], pick_gap());

      @(negedge clock);
      start <= 1'b0;

      // drain outstanding results, then watch for stray strobes
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (sb.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
